FILE: sv/assert_macros.svh
// Assertion macros shared by the fan PWM and tachometer RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define FPT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fpt assertion failed");

// Condition that must never hold outside reset.
`define FPT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("fpt forbidden condition");

`endif

FILE: sv/fpt_pkg.sv
// Package for the fan PWM and tachometer unit: widths, codes, request type.
// No dependencies.
package fpt_pkg;

  localparam int NUM_FANS_DEF   = 2;
  localparam int TIMER_BITS_DEF = 32;

  localparam int PERIOD_W = 10;
  localparam int PPR_W    = 4;
  localparam int VAL_W    = 10;
  localparam int SPEED_W  = 7;
  localparam int PULSE_W  = 15;
  localparam int EMS_W    = 23;
  localparam int RPM_W    = 32;
  localparam int ERR_W    = 2;
  localparam int LVL_W    = 2;
  localparam int NUM_W    = 41;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd43;
  localparam logic [PPR_W-1:0]    PPR_RST    = 4'd2;
  localparam logic [PULSE_W-1:0]  PULSE_MAX  = 15'd32767;
  localparam logic [25:0]         US_PER_MIN = 26'd60000000;
  localparam logic [EMS_W-1:0]    EMS_MAX    = 23'h7FFFFF;
  localparam logic [RPM_W-1:0]    RPM_MAX    = 32'hFFFFFFFF;
  localparam logic [SPEED_W-1:0]  SPEED_FULL = 7'd100;

  localparam logic CFG_PERIOD = 1'b0;
  localparam logic CFG_PPR    = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ARG   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_STATE = 2'd2;

  typedef enum logic [2:0] {
    CMD_SET_DUTY  = 3'd0,
    CMD_SET_SPEED = 3'd1,
    CMD_RESTART   = 3'd2,
    CMD_READ      = 3'd3,
    CMD_STATUS    = 3'd4,
    CMD_TICK      = 3'd5,
    CMD_EDGE      = 3'd6
  } cmd_e;

  typedef struct packed {
    logic [2:0]       cmd;
    logic             fan_ok;
    logic [1:0]       fan;
    logic [VAL_W-1:0] value;
  } req_t;

endpackage

FILE: sv/fpt_front.sv
// Front end: accepts requests, classifies the fan, holds a two-entry queue.
// Depends on fpt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fpt_front #(
  parameter int NUM_FANS = fpt_pkg::NUM_FANS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               command_i,
  input  logic [1:0]               fan_i,
  input  logic [fpt_pkg::VAL_W-1:0] value_i,
  output logic                     q_valid_o,
  output fpt_pkg::req_t            q_req_o,
  input  logic                     q_pop_i
);
  import fpt_pkg::*;

  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;
  req_t       req_in;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = mem_q[rd_q];

  always_comb begin
    req_in.cmd    = command_i;
    req_in.fan    = fan_i;
    req_in.fan_ok = ({1'b0, fan_i} < 3'(NUM_FANS));
    req_in.value  = value_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= req_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  `FPT_NEVER(a_pop_empty, clk_i, rst_ni, q_pop_i && cnt_q == 2'd0)
  `FPT_NEVER(a_cnt_over, clk_i, rst_ni, cnt_q == 2'd3)
endmodule

FILE: sv/fpt_div.sv
// Restoring divider, one quotient bit per cycle, shared by the speed and rpm conversions.
// Depends on fpt_pkg.
module fpt_div #(
  parameter int DW = fpt_pkg::TIMER_BITS_DEF + fpt_pkg::PPR_W
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fpt_pkg::NUM_W-1:0] num_i,
  input  logic [DW-1:0]             den_i,
  output logic                      done_o,
  output logic [fpt_pkg::NUM_W-1:0] quo_o
);
  import fpt_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DW-1:0]    rem_q, rem_d, den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DW:0]      sh;

  assign sh     = {rem_q, num_q[NUM_W-1]};
  assign done_o = done_q;
  assign quo_o  = num_q;

  always_comb begin
    if (sh >= {1'b0, den_q}) begin
      rem_d = DW'(sh - {1'b0, den_q});
      num_d = {num_q[NUM_W-2:0], 1'b1};
    end else begin
      rem_d = sh[DW-1:0];
      num_d = {num_q[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: sv/fpt_back.sv
// Back end: per-fan state, command sequencer, divider control, result register.
// Depends on fpt_pkg, fpt_div and assert_macros.svh.
`include "assert_macros.svh"
module fpt_back #(
  parameter int NUM_FANS   = fpt_pkg::NUM_FANS_DEF,
  parameter int TIMER_BITS = fpt_pkg::TIMER_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [fpt_pkg::PERIOD_W-1:0] cfg_data_i,
  input  logic                         q_valid_i,
  input  fpt_pkg::req_t                q_req_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fpt_pkg::ERR_W-1:0]    error_o,
  output logic [fpt_pkg::LVL_W-1:0]    pwm_levels_o,
  output logic [fpt_pkg::VAL_W-1:0]    duty_ticks_o,
  output logic [fpt_pkg::SPEED_W-1:0]  speed_pct_o,
  output logic [fpt_pkg::PULSE_W-1:0]  pulses_o,
  output logic [fpt_pkg::EMS_W-1:0]    window_ms_o,
  output logic [fpt_pkg::RPM_W-1:0]    rpm_o,
  output logic                         pulse_seen_o,
  output logic [fpt_pkg::ERR_W-1:0]    stored_err_o
);
  import fpt_pkg::*;

  localparam int FW = (NUM_FANS > 1) ? $clog2(NUM_FANS) : 1;
  localparam int DW = TIMER_BITS + PPR_W;

  // x/100 = (x*RECIP_100)>>24 for x < 2^17; x/125 = (x*RECIP_125)>>37 for x < 2^30
  localparam logic [17:0] RECIP_100  = 18'd167773;
  localparam logic [30:0] RECIP_125  = 31'd1099511628;
  localparam logic [63:0] US_EMS_SAT = 64'd8388608000;

  typedef enum logic [2:0] {S_IDLE, S_SDUTY, S_DSTART, S_DSPD, S_RPM, S_OUT} state_e;

  state_e state_q;
  req_t   cur_q;

  logic [PERIOD_W-1:0] period_q, p_eff, cnt_pwm_q;
  logic [PPR_W-1:0]    ppr_q, ppr_eff;

  logic [VAL_W-1:0]      duty_q   [NUM_FANS];
  logic [SPEED_W-1:0]    speed_q  [NUM_FANS];
  logic                  open_q   [NUM_FANS];
  logic [TIMER_BITS-1:0] us_q     [NUM_FANS];
  logic [PULSE_W-1:0]    pcnt_q   [NUM_FANS];
  logic [PULSE_W-1:0]    rpul_q   [NUM_FANS];
  logic [RPM_W-1:0]      rrpm_q   [NUM_FANS];
  logic                  rsig_q   [NUM_FANS];
  logic [ERR_W-1:0]      ferr_q   [NUM_FANS];

  logic [ERR_W-1:0]  err_q;
  logic [EMS_W-1:0]  ems_q;
  logic [VAL_W-1:0]  duty_tmp_q;
  logic              div_start_q;
  logic [NUM_W-1:0]  div_num_q, div_quo;
  logic [DW-1:0]     div_den_q;
  logic              div_done;

  logic              out_valid_q;
  logic [ERR_W-1:0]  o_err_q, o_lerr_q;
  logic [LVL_W-1:0]  o_lvl_q, lvl;
  logic [VAL_W-1:0]  o_duty_q;
  logic [SPEED_W-1:0] o_spd_q;
  logic [PULSE_W-1:0] o_pul_q;
  logic [EMS_W-1:0]  o_ems_q;
  logic [RPM_W-1:0]  o_rpm_q;
  logic              o_sig_q;

  logic [FW-1:0]     fi, fc;
  logic [PERIOD_W:0] cnt_nxt;
  logic              out_free;
  logic [34:0]       sd_prod;
  logic [VAL_W-1:0]  sd_duty;
  logic [63:0]       us_ext;
  logic [60:0]       ems_prod;
  logic [EMS_W-1:0]  ems_n;

  assign p_eff    = (period_q < PERIOD_W'(2)) ? PERIOD_W'(2) : period_q;
  assign ppr_eff  = (ppr_q == '0) ? PPR_W'(1) : ppr_q;
  assign fi       = q_req_i.fan[FW-1:0];
  assign fc       = cur_q.fan[FW-1:0];
  assign cnt_nxt  = {1'b0, cnt_pwm_q} + 1'b1;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  assign sd_prod  = div_num_q[16:0] * RECIP_100;
  assign sd_duty  = (sd_prod[34:24] > {1'b0, p_eff}) ? p_eff : sd_prod[33:24];
  assign us_ext   = 64'(us_q[fc]);
  assign ems_prod = us_ext[32:3] * RECIP_125;
  assign ems_n    = (us_ext >= US_EMS_SAT) ? EMS_MAX : ems_prod[59:37];

  for (genvar g = 0; g < LVL_W; g++) begin : g_lvl
    if (g < NUM_FANS) begin : g_on
      assign lvl[g] = (cnt_pwm_q < duty_q[g]);
    end else begin : g_off
      assign lvl[g] = 1'b0;
    end
  end

  fpt_div #(.DW(DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (div_num_q),
    .den_i  (div_den_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      ppr_q    <= PPR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PERIOD: period_q <= cfg_data_i;
        CFG_PPR:    ppr_q    <= cfg_data_i[PPR_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i) cur_q <= q_req_i;
    if (out_free && state_q == S_OUT) begin
      o_err_q <= err_q;
      o_lvl_q <= lvl;
      o_ems_q <= ems_q;
      if (cur_q.fan_ok) begin
        o_duty_q <= duty_q[fc];
        o_spd_q  <= speed_q[fc];
        o_pul_q  <= rpul_q[fc];
        o_rpm_q  <= rrpm_q[fc];
        o_sig_q  <= rsig_q[fc];
        o_lerr_q <= ferr_q[fc];
      end else begin
        o_duty_q <= '0;
        o_spd_q  <= '0;
        o_pul_q  <= '0;
        o_rpm_q  <= '0;
        o_sig_q  <= 1'b0;
        o_lerr_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_pwm_q   <= '0;
      err_q       <= ERR_OK;
      ems_q       <= '0;
      duty_tmp_q  <= '0;
      div_start_q <= 1'b0;
      div_num_q   <= '0;
      div_den_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_FANS; i++) begin
        duty_q[i]  <= '0;
        speed_q[i] <= SPEED_FULL;
        open_q[i]  <= 1'b0;
        us_q[i]    <= '0;
        pcnt_q[i]  <= '0;
        rpul_q[i]  <= '0;
        rrpm_q[i]  <= '0;
        rsig_q[i]  <= 1'b0;
        ferr_q[i]  <= ERR_OK;
      end
    end else begin
      div_start_q <= 1'b0;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            err_q   <= ERR_OK;
            ems_q   <= '0;
            state_q <= S_OUT;
            if (q_req_i.cmd == CMD_TICK) begin
              cnt_pwm_q <= (cnt_nxt >= {1'b0, p_eff}) ? '0 : cnt_nxt[PERIOD_W-1:0];
              for (int i = 0; i < NUM_FANS; i++) begin
                if (open_q[i] && !(&us_q[i])) us_q[i] <= us_q[i] + 1'b1;
              end
            end else if (!q_req_i.fan_ok) begin
              err_q <= ERR_ARG;
            end else begin
              case (q_req_i.cmd)
                CMD_SET_DUTY: begin
                  if (q_req_i.value > p_eff) begin
                    err_q <= ERR_ARG;
                  end else begin
                    duty_tmp_q  <= q_req_i.value;
                    div_num_q   <= NUM_W'(17'(p_eff - q_req_i.value) * 17'd100)
                                   + NUM_W'(p_eff[PERIOD_W-1:1]);
                    div_den_q   <= DW'(p_eff);
                    div_start_q <= 1'b1;
                    state_q     <= S_DSPD;
                  end
                end
                CMD_SET_SPEED: begin
                  if (q_req_i.value > VAL_W'(SPEED_FULL)) begin
                    err_q <= ERR_ARG;
                  end else begin
                    div_num_q <= NUM_W'(17'(SPEED_FULL - q_req_i.value[SPEED_W-1:0])
                                 * 17'(p_eff)) + NUM_W'(50);
                    state_q   <= S_SDUTY;
                  end
                end
                CMD_RESTART: begin
                  open_q[fi] <= 1'b1;
                  us_q[fi]   <= '0;
                  pcnt_q[fi] <= '0;
                  ferr_q[fi] <= ERR_OK;
                end
                CMD_READ: begin
                  if (!open_q[fi] || us_q[fi] == '0) begin
                    err_q      <= ERR_STATE;
                    ferr_q[fi] <= ERR_STATE;
                  end else begin
                    div_num_q   <= NUM_W'(NUM_W'(pcnt_q[fi]) * NUM_W'(US_PER_MIN));
                    div_den_q   <= DW'(DW'(ppr_eff) * DW'(us_q[fi]));
                    div_start_q <= 1'b1;
                    state_q     <= S_RPM;
                  end
                end
                CMD_STATUS: ;
                CMD_EDGE: begin
                  if (pcnt_q[fi] < PULSE_MAX) pcnt_q[fi] <= pcnt_q[fi] + 1'b1;
                end
                default: err_q <= ERR_ARG;
              endcase
            end
          end
        end
        S_SDUTY: begin
          duty_tmp_q <= sd_duty;
          state_q    <= S_DSTART;
        end
        S_DSTART: begin
          div_num_q   <= NUM_W'(17'(p_eff - duty_tmp_q) * 17'd100)
                         + NUM_W'(p_eff[PERIOD_W-1:1]);
          div_den_q   <= DW'(p_eff);
          div_start_q <= 1'b1;
          state_q     <= S_DSPD;
        end
        S_DSPD: begin
          if (div_done) begin
            duty_q[fc]  <= duty_tmp_q;
            speed_q[fc] <= (div_quo > NUM_W'(SPEED_FULL)) ? SPEED_FULL
                           : div_quo[SPEED_W-1:0];
            ferr_q[fc]  <= ERR_OK;
            state_q     <= S_OUT;
          end
        end
        S_RPM: begin
          if (div_done) begin
            rrpm_q[fc]  <= (|div_quo[NUM_W-1:RPM_W]) ? RPM_MAX : div_quo[RPM_W-1:0];
            rpul_q[fc]  <= pcnt_q[fc];
            rsig_q[fc]  <= (pcnt_q[fc] != '0);
            ferr_q[fc]  <= ERR_OK;
            ems_q       <= ems_n;
            state_q     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign error_o      = o_err_q;
  assign pwm_levels_o = o_lvl_q;
  assign duty_ticks_o = o_duty_q;
  assign speed_pct_o  = o_spd_q;
  assign pulses_o     = o_pul_q;
  assign window_ms_o  = o_ems_q;
  assign rpm_o        = o_rpm_q;
  assign pulse_seen_o = o_sig_q;
  assign stored_err_o = o_lerr_q;

  `FPT_ASSERT(a_div_start_state, clk_i, rst_ni,
    div_start_q |-> (state_q == S_DSPD || state_q == S_RPM))
endmodule

FILE: sv/fan_pwm_and_tachometer_unit.sv
// Top level of the fan PWM and tachometer unit: front queue plus back sequencer.
// Depends on fpt_pkg, fpt_front and fpt_back.
//
// One request gives one result. Tick, edge, restart, status and rejected
// requests go from the queue through S_OUT to the result register. The shared
// 41-step restoring divider serves the rest: set_duty and a successful tach_read
// wait on it, and set_speed first does a reciprocal multiply for the duty, then
// the speed division. The front queue holds two requests while the back works.
module fan_pwm_and_tachometer_unit #(
  parameter int NUM_FANS   = fpt_pkg::NUM_FANS_DEF,
  parameter int TIMER_BITS = fpt_pkg::TIMER_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [fpt_pkg::PERIOD_W-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   command_i,
  input  logic [1:0]                   fan_i,
  input  logic [fpt_pkg::VAL_W-1:0]    value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fpt_pkg::ERR_W-1:0]    error_o,
  output logic [fpt_pkg::LVL_W-1:0]    pwm_levels_o,
  output logic [fpt_pkg::VAL_W-1:0]    duty_ticks_o,
  output logic [fpt_pkg::SPEED_W-1:0]  speed_pct_o,
  output logic [fpt_pkg::PULSE_W-1:0]  pulses_o,
  output logic [fpt_pkg::EMS_W-1:0]    window_ms_o,
  output logic [fpt_pkg::RPM_W-1:0]    rpm_o,
  output logic                         pulse_seen_o,
  output logic [fpt_pkg::ERR_W-1:0]    stored_err_o
);
  import fpt_pkg::*;

  logic q_valid, q_pop;
  req_t q_req;

  fpt_front #(.NUM_FANS(NUM_FANS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .command_i (command_i),
    .fan_i     (fan_i),
    .value_i   (value_i),
    .q_valid_o (q_valid),
    .q_req_o   (q_req),
    .q_pop_i   (q_pop)
  );

  fpt_back #(.NUM_FANS(NUM_FANS), .TIMER_BITS(TIMER_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_req_i     (q_req),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .error_o     (error_o),
    .pwm_levels_o(pwm_levels_o),
    .duty_ticks_o(duty_ticks_o),
    .speed_pct_o (speed_pct_o),
    .pulses_o    (pulses_o),
    .window_ms_o (window_ms_o),
    .rpm_o       (rpm_o),
    .pulse_seen_o(pulse_seen_o),
    .stored_err_o(stored_err_o)
  );
endmodule

FILE: tb/fpt_checker.sv
// Checker for the fan PWM and tachometer unit: watches the config port and both
// channels, predicts each result and compares it as a whole. Depends on fpt_pkg.
`timescale 1ns / 1ps
module fpt_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [fpt_pkg::PERIOD_W-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [2:0]                   command_i,
  input  logic [1:0]                   fan_i,
  input  logic [fpt_pkg::VAL_W-1:0]    value_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [fpt_pkg::ERR_W-1:0]    error_i,
  input  logic [fpt_pkg::LVL_W-1:0]    pwm_levels_i,
  input  logic [fpt_pkg::VAL_W-1:0]    duty_ticks_i,
  input  logic [fpt_pkg::SPEED_W-1:0]  speed_pct_i,
  input  logic [fpt_pkg::PULSE_W-1:0]  pulses_i,
  input  logic [fpt_pkg::EMS_W-1:0]    window_ms_i,
  input  logic [fpt_pkg::RPM_W-1:0]    rpm_i,
  input  logic                         pulse_seen_i,
  input  logic [fpt_pkg::ERR_W-1:0]    stored_err_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import fpt_pkg::*;

  localparam int NF = NUM_FANS_DEF;

  typedef struct packed {
    logic [ERR_W-1:0]   err;
    logic [LVL_W-1:0]   lvl;
    logic [VAL_W-1:0]   duty;
    logic [SPEED_W-1:0] speed;
    logic [PULSE_W-1:0] pulses;
    logic [EMS_W-1:0]   ems;
    logic [RPM_W-1:0]   rpm;
    logic               sig;
    logic [ERR_W-1:0]   lerr;
  } result_t;

  result_t status_q[$];

  logic [PERIOD_W-1:0] period;
  logic [PPR_W-1:0]    ppr;
  logic [PERIOD_W-1:0] pwm_cnt;
  logic [VAL_W-1:0]    duty[NF];
  logic [SPEED_W-1:0]  speed[NF];
  logic                win_open[NF];
  logic [31:0]         win_us[NF];
  logic [PULSE_W-1:0]  pcount[NF];
  logic [PULSE_W-1:0]  rd_pulses[NF];
  logic [RPM_W-1:0]    rd_rpm[NF];
  logic                rd_sig[NF];
  logic [ERR_W-1:0]    ferr[NF];

  function automatic logic [31:0] eff_period();
    return (period < 2) ? 32'd2 : 32'(period);
  endfunction

  function automatic logic [SPEED_W-1:0] speed_of(logic [31:0] d);
    logic [31:0] p, rel, s;
    p = eff_period();
    rel = (d > p) ? 0 : p - d;
    s = (rel * 100 + p / 2) / p;
    return (s > 100) ? SPEED_FULL : SPEED_W'(s);
  endfunction

  function automatic logic [VAL_W-1:0] duty_of(logic [31:0] s);
    logic [31:0] p, d;
    p = eff_period();
    d = ((100 - s) * p + 50) / 100;
    return (d > p) ? VAL_W'(p) : VAL_W'(d);
  endfunction

  task automatic predict_status(input logic [2:0] cmd, input logic [1:0] f,
                                input logic [VAL_W-1:0] val, output result_t r);
    logic [63:0] us, div, num, q;
    logic [31:0] nxt;
    logic [VAL_W-1:0] nd;
    r = '0;
    if (cmd == CMD_TICK) begin
      nxt = 32'(pwm_cnt) + 1;
      pwm_cnt = (nxt >= eff_period()) ? '0 : PERIOD_W'(nxt);
      for (int i = 0; i < NF; i++)
        if (win_open[i] && win_us[i] != 32'hFFFFFFFF) win_us[i]++;
    end else if (cmd == 3'd7 || f >= NF) begin
      r.err = ERR_ARG;
    end else if (cmd == CMD_SET_DUTY || cmd == CMD_SET_SPEED) begin
      if (cmd == CMD_SET_DUTY) begin
        if (32'(val) > eff_period()) r.err = ERR_ARG;
        nd = val;
      end else begin
        if (val > 100) r.err = ERR_ARG;
        nd = (r.err == ERR_OK) ? duty_of(32'(val)) : '0;
      end
      if (r.err == ERR_OK) begin
        duty[f] = nd;
        speed[f] = speed_of(32'(nd));
        ferr[f] = ERR_OK;
      end
    end else if (cmd == CMD_RESTART) begin
      win_open[f] = 1'b1;
      win_us[f] = '0;
      pcount[f] = '0;
      ferr[f] = ERR_OK;
    end else if (cmd == CMD_READ) begin
      if (!win_open[f] || win_us[f] == 0) begin
        r.err = ERR_STATE;
        ferr[f] = ERR_STATE;
      end else begin
        us = 64'(win_us[f]);
        div = ((ppr == 0) ? 64'd1 : 64'(ppr)) * us;
        num = 64'(pcount[f]) * 64'd60000000;
        q = num / div;
        r.ems = ((us / 1000) > 64'(EMS_MAX)) ? EMS_MAX : EMS_W'(us / 1000);
        rd_pulses[f] = pcount[f];
        rd_rpm[f] = (q > 64'(RPM_MAX)) ? RPM_MAX : RPM_W'(q);
        rd_sig[f] = (pcount[f] != 0);
        ferr[f] = ERR_OK;
      end
    end else if (cmd == CMD_EDGE) begin
      if (pcount[f] < PULSE_MAX) pcount[f]++;
    end
    for (int i = 0; i < NF; i++)
      if (32'(pwm_cnt) < 32'(duty[i])) r.lvl[i] = 1'b1;
    if (f < NF) begin
      r.duty = duty[f];
      r.speed = speed[f];
      r.pulses = rd_pulses[f];
      r.rpm = rd_rpm[f];
      r.sig = rd_sig[f];
      r.lerr = ferr[f];
    end else begin
      r.ems = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r, got, pred;
    if (!rst_ni) begin
      period = PERIOD_RST;
      ppr = PPR_RST;
      pwm_cnt = '0;
      for (int i = 0; i < NF; i++) begin
        duty[i] = '0; speed[i] = SPEED_FULL; win_open[i] = 1'b0; win_us[i] = '0;
        pcount[i] = '0; rd_pulses[i] = '0; rd_rpm[i] = '0; rd_sig[i] = 1'b0;
        ferr[i] = ERR_OK;
      end
      fail_count_o = 0;
      status_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_PERIOD) period = cfg_data_i;
        else ppr = cfg_data_i[PPR_W-1:0];
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{error_i, pwm_levels_i, duty_ticks_i, speed_pct_i, pulses_i,
                window_ms_i, rpm_i, pulse_seen_i, stored_err_i};
        if (status_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = status_q.pop_front();
          if (got !== exp_r) begin
            fail_count_o++;
            if (fail_count_o <= 10) $display("mismatch: expected %p got %p", exp_r, got);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_status(command_i, fan_i, value_i, pred);
        status_q.push_back(pred);
      end
      pending_o = status_q.size();
    end
  end
endmodule

FILE: tb/tb_fan_pwm_and_tachometer_unit.sv
// Testbench top for the fan PWM and tachometer unit: clock, reset, requests,
// config phases and verdict. Depends on fpt_pkg, fpt_checker and the RTL.
`timescale 1ns / 1ps
module tb_fan_pwm_and_tachometer_unit;
  import fpt_pkg::*;

  localparam logic [2:0] CMD_BAD = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk, rst_n;
  logic cfg_we = 1'b0, cfg_index = CFG_PERIOD;
  logic [PERIOD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
  logic [2:0] command = '0;
  logic [1:0] fan = '0;
  logic [VAL_W-1:0] value = '0;
  logic [ERR_W-1:0] error, stored_err;
  logic [LVL_W-1:0] pwm_levels;
  logic [VAL_W-1:0] duty_ticks;
  logic [SPEED_W-1:0] speed_pct;
  logic [PULSE_W-1:0] pulses;
  logic [EMS_W-1:0] window_ms;
  logic [RPM_W-1:0] rpm;
  logic pulse_seen;
  int fails, pending, tx_idle, rx_idle, idle_cnt, cur_period;

  fan_pwm_and_tachometer_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .fan_i(fan), .value_i(value), .out_valid_o(out_valid),
    .out_stall_i(out_stall), .error_o(error), .pwm_levels_o(pwm_levels),
    .duty_ticks_o(duty_ticks), .speed_pct_o(speed_pct), .pulses_o(pulses),
    .window_ms_o(window_ms), .rpm_o(rpm), .pulse_seen_o(pulse_seen),
    .stored_err_o(stored_err)
  );

  fpt_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .command_i(command), .fan_i(fan), .value_i(value), .out_valid_i(out_valid),
    .out_stall_i(out_stall), .error_i(error), .pwm_levels_i(pwm_levels),
    .duty_ticks_i(duty_ticks), .speed_pct_i(speed_pct), .pulses_i(pulses),
    .window_ms_i(window_ms), .rpm_i(rpm), .pulse_seen_i(pulse_seen),
    .stored_err_i(stored_err), .fail_count_o(fails), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < rx_idle);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("** fan_pwm_and_tachometer_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_req(input logic [2:0] c, input logic [1:0] f, input int v);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    fan <= f;
    value <= VAL_W'(v);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input int data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= PERIOD_W'(data);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PERIOD) cur_period = (data % 1024 < 2) ? 2 : data % 1024;
  endtask

  task automatic send_random();
    int r;
    logic [1:0] f;
    r = $urandom_range(99);
    f = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1));
    if (r < 35) send_req(CMD_TICK, 2'($urandom_range(3)), $urandom_range(1023));
    else if (r < 55) send_req(CMD_EDGE, f, $urandom_range(1023));
    else if (r < 65) send_req(CMD_READ, f, $urandom_range(1023));
    else if (r < 70) send_req(CMD_RESTART, f, $urandom_range(1023));
    else if (r < 80)
      send_req(CMD_SET_DUTY, f, ($urandom_range(7) == 0) ? $urandom_range(1023)
                                                       : $urandom_range(cur_period));
    else if (r < 90)
      send_req(CMD_SET_SPEED, f, ($urandom_range(7) == 0) ? $urandom_range(1023)
                                                        : $urandom_range(100));
    else if (r < 97) send_req(CMD_STATUS, f, $urandom_range(1023));
    else send_req(CMD_BAD, f, $urandom_range(1023));
  endtask

  initial begin
    tx_idle = 0;
    rx_idle = 0;
    cur_period = 43;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(CMD_STATUS, 2'd0, 0);
    send_req(CMD_READ, 2'd0, 0);
    send_req(CMD_RESTART, 2'd0, 0);
    send_req(CMD_READ, 2'd0, 0);
    send_req(CMD_SET_DUTY, 2'd0, 0);
    send_req(CMD_SET_DUTY, 2'd1, 43);
    send_req(CMD_SET_DUTY, 2'd0, 44);
    send_req(CMD_SET_DUTY, 2'd1, 1023);
    send_req(CMD_SET_SPEED, 2'd0, 0);
    send_req(CMD_SET_SPEED, 2'd1, 100);
    send_req(CMD_SET_SPEED, 2'd0, 101);
    send_req(CMD_SET_SPEED, 2'd1, 1023);
    send_req(CMD_SET_DUTY, 2'd2, 5);
    send_req(CMD_READ, 2'd3, 5);
    send_req(CMD_TICK, 2'd3, 1023);
    send_req(CMD_BAD, 2'd0, 0);
    send_req(CMD_EDGE, 2'd1, 0);
    send_req(CMD_RESTART, 2'd1, 0);
    send_req(CMD_EDGE, 2'd1, 0);
    send_req(CMD_TICK, 2'd0, 0);
    send_req(CMD_TICK, 2'd1, 0);
    send_req(CMD_READ, 2'd1, 0);
    send_req(CMD_READ, 2'd0, 0);
    send_req(CMD_STATUS, 2'd1, 0);
    settle();

    // rpm saturation with a one-tick window
    cfg_write(CFG_PPR, 0);
    send_req(CMD_RESTART, 2'd0, 0);
    repeat (80) send_req(CMD_EDGE, 2'd0, 0);
    send_req(CMD_TICK, 2'd0, 0);
    send_req(CMD_READ, 2'd0, 0);
    settle();
    // counter wrap after shrink
    cfg_write(CFG_PERIOD, 1023);
    cfg_write(CFG_PPR, 8);
    send_req(CMD_SET_DUTY, 2'd1, 1023);
    repeat (40) send_req(CMD_TICK, 2'($urandom_range(3)), 0);
    send_req(CMD_READ, 2'd0, 0);
    send_req(CMD_READ, 2'd1, 0);
    settle();
    cfg_write(CFG_PERIOD, 1);
    cfg_write(CFG_PPR, 15);
    send_req(CMD_TICK, 2'd0, 0);
    send_req(CMD_SET_SPEED, 2'd0, 50);
    send_req(CMD_TICK, 2'd0, 0);
    settle();

    tx_idle = 18;
    rx_idle = 51;
    cfg_write(CFG_PERIOD, 43);
    cfg_write(CFG_PPR, 2);
    repeat (300) send_random();
    settle();

    tx_idle = 51;
    rx_idle = 18;
    cfg_write(CFG_PERIOD, 0);
    cfg_write(CFG_PPR, 1);
    repeat (150) send_random();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) send_random();
    settle();

    tx_idle = 0;
    rx_idle = 0;
    cfg_write(CFG_PERIOD, $urandom_range(1023, 2));
    cfg_write(CFG_PPR, $urandom_range(15));
    repeat (390) send_random();
    settle();

    if (fails == 0) $display("** fan_pwm_and_tachometer_unit: PASSED **");
    else $display("** fan_pwm_and_tachometer_unit: FAILED **");
    $finish;
  end
endmodule
